/* hw/rtl/lzir_pkg.sv */
// Package for the LZ77 image row decompressor: widths, codes, transaction structs
// and the row/image size clamp. No dependencies.
`timescale 1ns / 1ps

package lzir_pkg;

   localparam int HIST_DEPTH    = 1024;
   localparam int HIST_AW       = 10;
   localparam int MIN_MATCH_DEF = 3;
   localparam int MAX_RESULTS   = 34;
   localparam int CFG_W         = 14;
   localparam int POS_W         = 13;
   localparam int COUNT_W       = 24;
   localparam int SIZE_MAX      = 8192;

   // decode phase codes
   localparam logic [1:0] PH_CODE    = 2'd0;
   localparam logic [1:0] PH_LITERAL = 2'd1;
   localparam logic [1:0] PH_OFFSET  = 2'd2;

   // result status codes
   localparam logic [1:0] ST_DATA  = 2'd0;
   localparam logic [1:0] ST_SHORT = 2'd1;
   localparam logic [1:0] ST_PHASE = 2'd2;

   // register indexes
   localparam logic REG_BYTES_PER_ROW = 1'b0;
   localparam logic REG_ROW_COUNT     = 1'b1;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [7:0]         out_byte;
      logic               row_end;
      logic               image_done;
      logic               run_last;
      logic [1:0]         status;
      logic [COUNT_W-1:0] consumed_count;
   } rsp_type;

   // zero reads as one, anything above the maximum as the maximum
   function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] v);
      logic [CFG_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = CFG_W'(1);
      end else if (v > CFG_W'(SIZE_MAX)) begin
         r = CFG_W'(SIZE_MAX);
      end
      return r;
   endfunction

endpackage

/* hw/rtl/lz77_image_row_decompressor.sv */
// LZ77 image row decompressor top level: sequencer, 1024-byte history ring,
// output register. Depends on lzir_pkg.
`timescale 1ns / 1ps

// Takes one compressed byte per req transaction and returns the decoded pixel
// bytes as rsp transactions, with row_end / image_done / run_last flags and an
// error status. A code byte or an offset-free byte is taken in the idle state; a
// literal byte is accepted, then emitted. A back-reference of length L makes one
// history read ahead, then one ring byte per cycle unless the output stalls,
// through the single read port, with a write-to-read bypass for overlapping
// copies. Early-end status has its own state. Output stalls hold the sequencer.
// req_ready is low while a transaction is in work. The history ring needs no
// clearing pass: a fill mark makes never-written entries read as zero. After
// image done or any error, transactions are accepted and dropped until reset.
module lz77_image_row_decompressor #(
   parameter int MIN_MATCH = lzir_pkg::MIN_MATCH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  lzir_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output lzir_pkg::rsp_type          rsp_data,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [lzir_pkg::CFG_W-1:0] csr_wdata
);

   localparam int AW    = lzir_pkg::HIST_AW;
   localparam int CW    = lzir_pkg::CFG_W;
   localparam int PW    = lzir_pkg::POS_W;
   localparam int NW    = lzir_pkg::COUNT_W;
   localparam int LEN_W = $clog2(31 + MIN_MATCH + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LIT  = 2'd1;
   localparam logic [1:0] S_REF  = 2'd2;
   localparam logic [1:0] S_STAT = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [1:0]       phase_ff, phase_in;
   logic [7:0]       lit_left_ff, lit_left_in;
   logic [6:0]       pend_ff, pend_in;
   logic [PW-1:0]    col_ff, col_in;
   logic [PW-1:0]    row_ff, row_in;
   logic             finished_ff, finished_in;
   logic             row_full_ff, row_full_in;
   logic [NW-1:0]    count_ff, count_in;
   logic [CW-1:0]    bpr_ff, bpr_in;
   logic [CW-1:0]    rc_ff, rc_in;
   logic [AW-1:0]    wp_ff, wp_in;
   logic             wrapped_ff, wrapped_in;
   logic             rsp_valid_ff, rsp_valid_in;
   lzir_pkg::rsp_type rsp_ff, rsp_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic             rzero_ff, rzero_in;
   logic             fwd_ff, fwd_in;
   logic [7:0]       fwd_data_ff;
   logic [7:0]       rdata_ff;

   logic [7:0]       ring_mem [lzir_pkg::HIST_DEPTH];

   logic             accept, slot_free, emit_byte, emit;
   logic [7:0]       ref_data, pb_b;
   logic [LEN_W-1:0] idx_next;
   logic             pb_last_run, step_end, col_last, row_last;
   logic             pb_err, pb_done, fin_after, need_status, replace;
   logic             we, rd_en;
   logic [AW-1:0]    rd_addr;
   logic [CW-1:0]    bpr_eff, rc_eff;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign emit_byte = ((state_ff == S_LIT) || (state_ff == S_REF)) && slot_free;

   assign bpr_eff  = lzir_pkg::eff_size(bpr_ff);
   assign rc_eff   = lzir_pkg::eff_size(rc_ff);
   assign ref_data = rzero_ff ? 8'd0 : (fwd_ff ? fwd_data_ff : rdata_ff);
   assign pb_b     = (state_ff == S_LIT) ? byte_ff : ref_data;
   assign idx_next = idx_ff + LEN_W'(1);

   assign pb_last_run = (state_ff == S_LIT) ? (lit_left_ff <= 8'd1) : (idx_next == len_ff);
   assign step_end    = (state_ff == S_LIT) || (idx_next == len_ff);
   assign col_last    = ({1'b0, col_ff} + CW'(1)) >= bpr_eff;
   assign row_last    = ({1'b0, row_ff} + CW'(1)) >= rc_eff;
   assign pb_err      = row_full_ff;
   assign pb_done     = !pb_err && col_last && pb_last_run && row_last;
   assign fin_after   = pb_err || pb_done;
   assign need_status = step_end && last_ff && !fin_after;
   // a full-length reference that ends the stream gives its last slot to the status
   assign replace     = need_status && (state_ff == S_REF) &&
                        (idx_next >= LEN_W'(lzir_pkg::MAX_RESULTS));
   assign we          = emit_byte && !pb_err;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      lit_left_in  = lit_left_ff;
      pend_in      = pend_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      finished_in  = finished_ff;
      row_full_in  = row_full_ff;
      count_in     = count_ff;
      bpr_in       = bpr_ff;
      rc_in        = rc_ff;
      wp_in        = wp_ff;
      wrapped_in   = wrapped_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      rd_ptr_in    = rd_ptr_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      rd_en        = 1'b0;
      rd_addr      = rd_ptr_ff;
      emit         = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            lzir_pkg::REG_BYTES_PER_ROW: bpr_in = csr_wdata;
            lzir_pkg::REG_ROW_COUNT:     rc_in  = csr_wdata;
            default:                     bpr_in = bpr_ff;
         endcase
      end

      unique case (state_ff) inside
         S_IDLE: begin
            if (accept && !finished_ff) begin
               if (count_ff != '1) begin
                  count_in = count_ff + NW'(1);
               end
               byte_in = req_data.in_byte;
               last_in = req_data.is_last;
               unique case (phase_ff)
                  lzir_pkg::PH_CODE: begin
                     if (req_data.in_byte[7]) begin
                        lit_left_in = req_data.in_byte - 8'd127;
                        phase_in    = lzir_pkg::PH_LITERAL;
                     end else begin
                        pend_in  = req_data.in_byte[6:0];
                        phase_in = lzir_pkg::PH_OFFSET;
                     end
                     state_in = req_data.is_last ? S_STAT : S_IDLE;
                  end
                  lzir_pkg::PH_LITERAL: begin
                     state_in = S_LIT;
                  end
                  lzir_pkg::PH_OFFSET: begin
                     phase_in  = lzir_pkg::PH_CODE;
                     // wp - (offset + 1) == wp + ~offset in ring arithmetic
                     rd_addr   = wp_ff + ~{pend_ff[1:0], req_data.in_byte};
                     rd_en     = 1'b1;
                     rd_ptr_in = rd_addr;
                     len_in    = LEN_W'(pend_ff[6:2]) + LEN_W'(MIN_MATCH);
                     idx_in    = '0;
                     state_in  = S_REF;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_LIT, S_REF: begin
            if (emit_byte) begin
               emit                  = 1'b1;
               rsp_in.consumed_count = count_ff;
               rsp_in.out_byte       = 8'd0;
               rsp_in.row_end        = 1'b0;
               rsp_in.image_done     = 1'b0;
               rsp_in.run_last       = 1'b1;
               if (pb_err) begin
                  rsp_in.status = lzir_pkg::ST_PHASE;
                  finished_in   = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  wp_in = wp_ff + AW'(1);
                  if (wp_ff == '1) begin
                     wrapped_in = 1'b1;
                  end
                  if (col_last) begin
                     if (pb_last_run) begin
                        if (row_last) begin
                           finished_in = 1'b1;
                        end else begin
                           row_in = row_ff + PW'(1);
                           col_in = '0;
                        end
                     end else begin
                        row_full_in = 1'b1;
                     end
                  end else begin
                     col_in = col_ff + PW'(1);
                  end
                  if (replace) begin
                     rsp_in.status = lzir_pkg::ST_SHORT;
                     finished_in   = 1'b1;
                  end else begin
                     rsp_in.status     = lzir_pkg::ST_DATA;
                     rsp_in.out_byte   = pb_b;
                     rsp_in.row_end    = col_last;
                     rsp_in.image_done = pb_done;
                     rsp_in.run_last   = step_end && !need_status;
                  end
                  if (state_ff == S_LIT) begin
                     lit_left_in = pb_last_run ? 8'd0 : lit_left_ff - 8'd1;
                     if (pb_last_run) begin
                        phase_in = lzir_pkg::PH_CODE;
                     end
                  end
                  if (step_end) begin
                     state_in = (need_status && !replace) ? S_STAT : S_IDLE;
                  end else begin
                     idx_in    = idx_next;
                     rd_addr   = rd_ptr_ff + AW'(1);
                     rd_ptr_in = rd_addr;
                     rd_en     = 1'b1;
                  end
               end
            end
         end
         S_STAT: begin
            if (slot_free) begin
               emit                  = 1'b1;
               rsp_in.out_byte       = 8'd0;
               rsp_in.row_end        = 1'b0;
               rsp_in.image_done     = 1'b0;
               rsp_in.run_last       = 1'b1;
               rsp_in.status         = lzir_pkg::ST_SHORT;
               rsp_in.consumed_count = count_ff;
               finished_in           = 1'b1;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   // bypass the write when the read hits the entry written at the same edge
   assign fwd_in   = we && (rd_addr == wp_ff);
   assign rzero_in = !fwd_in && !wrapped_ff && (rd_addr >= wp_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= lzir_pkg::PH_CODE;
         lit_left_ff  <= '0;
         pend_ff      <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         finished_ff  <= 1'b0;
         row_full_ff  <= 1'b0;
         count_ff     <= '0;
         bpr_ff       <= CW'(1);
         rc_ff        <= CW'(1);
         wp_ff        <= '0;
         wrapped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         lit_left_ff  <= lit_left_in;
         pend_ff      <= pend_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         finished_ff  <= finished_in;
         row_full_ff  <= row_full_in;
         count_ff     <= count_in;
         bpr_ff       <= bpr_in;
         rc_ff        <= rc_in;
         wp_ff        <= wp_in;
         wrapped_ff   <= wrapped_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff    <= rsp_in;
      byte_ff   <= byte_in;
      last_ff   <= last_in;
      rd_ptr_ff <= rd_ptr_in;
      len_ff    <= len_in;
      if (rd_en) begin
         rzero_ff    <= rzero_in;
         fwd_ff      <= fwd_in;
         fwd_data_ff <= pb_b;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         ring_mem[wp_ff] <= pb_b;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= ring_mem[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_quiet_after_finish: assert property (@(posedge clock) disable iff (reset)
      (finished_ff && (state_ff == S_IDLE) && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("result after finish");

   a_short_sets_finish: assert property (@(posedge clock) disable iff (reset)
      (emit && (rsp_in.status == lzir_pkg::ST_SHORT)) |=> finished_ff)
      else $error("early-end status without finish");

   a_ref_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REF) |-> (idx_ff < len_ff))
      else $error("reference index past length");

   a_done_is_run_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.image_done) |-> rsp_ff.run_last)
      else $error("image done without run_last");
`endif

endmodule

/* sim/lz77_image_row_decompressor_tb.sv */
// Self-checking testbench for lz77_image_row_decompressor: literal runs and history copies
// against a scoreboard that decodes the same stream. Depends on lzir_pkg and the block's RTL.
`timescale 1ns / 1ps

module lz77_image_row_decompressor_tb;

   localparam int IDLE_PCT    = 8;
   localparam int RUN_SETTLE  = 50;    // a full-length copy plus status result, with margin
   localparam int STALL_LIMIT = 2000;  // cycles with no transaction on either channel

   // Decodes the compressed stream on its own and queues the pixel results it implies.
   class pixel_scoreboard;
      logic [7:0]  history [lzir_pkg::HIST_DEPTH];
      logic [9:0]  write_pos;
      logic [1:0]  phase;
      int unsigned literal_left;
      logic [6:0]  pending_code;
      int unsigned column_pos;
      int unsigned row_pos;
      bit          finished;
      bit          row_full;
      logic [23:0] consumed;
      logic [13:0] bytes_per_row;
      logic [13:0] row_count;
      lzir_pkg::rsp_type step_q[$];
      lzir_pkg::rsp_type pixels_due[$];
      int unsigned mismatches;
      int unsigned items_taken;
      int unsigned results_seen;
      int unsigned rows_done;

      function new();
         foreach (history[i]) history[i] = 8'h00;
         write_pos     = '0;
         phase         = lzir_pkg::PH_CODE;
         literal_left  = 0;
         pending_code  = '0;
         column_pos    = 0;
         row_pos       = 0;
         finished      = 0;
         row_full      = 0;
         consumed      = '0;
         bytes_per_row = 14'd1;
         row_count     = 14'd1;
         mismatches    = 0;
         items_taken   = 0;
         results_seen  = 0;
         rows_done     = 0;
      endfunction

      static function int unsigned clamp_size(logic [13:0] v);
         return (v == 0) ? 1 : ((v > lzir_pkg::SIZE_MAX) ? lzir_pkg::SIZE_MAX : int'(v));
      endfunction

      function void write_register(logic idx, logic [13:0] value);
         if (idx == lzir_pkg::REG_BYTES_PER_ROW) bytes_per_row = value;
         else row_count = value;
      endfunction

      // bytes a run may still place in the current row without crossing its end
      function int unsigned row_room();
         int unsigned width;
         width = clamp_size(bytes_per_row);
         return (column_pos < width) ? width - column_pos : 1;
      endfunction

      // returns 0 when the run has already filled the row (phase error)
      function bit emit_pixel(logic [7:0] b, bit run_end);
         lzir_pkg::rsp_type r;
         r = '0;
         r.consumed_count = consumed;
         if (row_full) begin
            r.status = lzir_pkg::ST_PHASE;
            step_q.push_back(r);
            finished = 1;
            return 0;
         end
         history[write_pos] = b;
         write_pos = write_pos + 10'd1;
         if (column_pos + 1 >= clamp_size(bytes_per_row)) begin
            r.row_end = 1'b1;
            rows_done++;
            if (run_end) begin
               if (row_pos + 1 >= clamp_size(row_count)) begin
                  r.image_done = 1'b1;
                  finished = 1;
               end else begin
                  row_pos = (row_pos + 1) & 'h1FFF;
                  column_pos = 0;
               end
            end else begin
               row_full = 1;
            end
         end else begin
            column_pos = (column_pos + 1) & 'h1FFF;
         end
         r.out_byte = b;
         r.status = lzir_pkg::ST_DATA;
         step_q.push_back(r);
         return 1;
      endfunction

      function void accept_byte(lzir_pkg::req_type t);
         bit          run_end;
         int unsigned distance;
         int unsigned count;
         logic [9:0]  rd;
         lzir_pkg::rsp_type r;
         items_taken++;
         if (finished) return;
         if (consumed != 24'hFFFFFF) consumed = consumed + 24'd1;
         step_q.delete();
         case (phase)
            lzir_pkg::PH_CODE: begin
               if (t.in_byte[7]) begin
                  literal_left = int'(t.in_byte) - 127;
                  phase = lzir_pkg::PH_LITERAL;
               end else begin
                  pending_code = t.in_byte[6:0];
                  phase = lzir_pkg::PH_OFFSET;
               end
            end
            lzir_pkg::PH_LITERAL: begin
               run_end = (literal_left <= 1);
               if (emit_pixel(t.in_byte, run_end)) begin
                  literal_left = run_end ? 0 : literal_left - 1;
                  if (run_end) phase = lzir_pkg::PH_CODE;
               end
            end
            default: begin
               distance = int'(t.in_byte) + (int'(pending_code[1:0]) << 8) + 1;
               rd = write_pos - 10'(distance);
               count = int'(pending_code[6:2]) + lzir_pkg::MIN_MATCH_DEF;
               phase = lzir_pkg::PH_CODE;
               for (int k = 0; k < count; k++) begin
                  r.out_byte = history[rd];
                  rd = rd + 10'd1;
                  if (!emit_pixel(r.out_byte, k + 1 == count)) break;
               end
            end
         endcase
         if (!finished && t.is_last) begin
            // a full-length copy has no slot left: the status result takes the last one
            if (step_q.size() >= lzir_pkg::MAX_RESULTS) void'(step_q.pop_back());
            r = '0;
            r.status = lzir_pkg::ST_SHORT;
            r.consumed_count = consumed;
            step_q.push_back(r);
            finished = 1;
         end
         if (step_q.size() > 0) begin
            r = step_q.pop_back();
            r.run_last = 1'b1;
            step_q.push_back(r);
         end
         foreach (step_q[i]) pixels_due.push_back(step_q[i]);
      endfunction

      function void match_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("field %s expected %0d actual %0d", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_pixel(lzir_pkg::rsp_type got);
         lzir_pkg::rsp_type want;
         if (pixels_due.size() == 0) begin
            $error("result with nothing pending: %p", got);
            mismatches++;
            return;
         end
         want = pixels_due.pop_front();
         results_seen++;
         match_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
         match_field("row_end", 32'(want.row_end), 32'(got.row_end));
         match_field("image_done", 32'(want.image_done), 32'(got.image_done));
         match_field("run_last", 32'(want.run_last), 32'(got.run_last));
         match_field("status", 32'(want.status), 32'(got.status));
         match_field("consumed_count", 32'(want.consumed_count), 32'(got.consumed_count));
      endfunction
   endclass

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   lzir_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   lzir_pkg::rsp_type rsp_data;
   logic              csr_we    = 1'b0;
   logic              csr_index = 1'b0;
   logic [lzir_pkg::CFG_W-1:0] csr_wdata = '0;

   bit              steady = 0;
   int unsigned     quiet_cycles = 0;
   pixel_scoreboard board = new();

   lz77_image_row_decompressor i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   // input is noted before any result of the same edge is checked
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) board.accept_byte(req_data);
      if (!reset && rsp_valid && rsp_ready) board.check_pixel(rsp_data);
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b, input bit last);
      lzir_pkg::req_type t;
      t.in_byte = b;
      t.is_last = last;
      if (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < 50) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // last_at: position of the is_last byte, 0 being the code byte; -1 for none
   task automatic send_literal(input int unsigned len, input int last_at);
      send_byte(8'(127 + len), last_at == 0);
      for (int i = 1; i <= len; i++) send_byte(8'($urandom_range(255)), last_at == i);
   endtask

   task automatic send_copy(input int unsigned len, input int unsigned distance, input bit last);
      send_byte({1'b0, 5'(len - 3), 2'((distance - 1) >> 8)}, 1'b0);
      send_byte(8'(distance - 1), last);
   endtask

   function automatic int unsigned pick_distance();
      return ($urandom_range(3) == 0) ? $urandom_range(1024, 1) : $urandom_range(40, 1);
   endfunction

   // one run that ends exactly at the row end, or a 128-byte literal if the row has more room
   task automatic send_row_fill();
      int unsigned room;
      room = board.row_room();
      if (room >= 3 && room <= 34 && $urandom_range(1)) send_copy(room, pick_distance(), 0);
      else send_literal(room < 128 ? room : 128, -1);
   endtask

   // one well-formed run that never crosses a row end
   task automatic send_random_run();
      int unsigned room;
      int unsigned cap;
      int unsigned len;
      int unsigned pick;
      room = board.row_room();
      pick = $urandom_range(19);
      if (room >= 3 && $urandom_range(1)) begin
         cap = (room < 34) ? room : 34;
         len = (pick < 5) ? cap : $urandom_range(cap, 3);
         send_copy(len, pick_distance(), 0);
      end else begin
         cap = (room < 128) ? room : 128;
         if (pick < 4 && cap <= 24) len = cap;
         else if (pick == 19 && $urandom_range(3) == 0) len = cap;
         else len = $urandom_range(cap < 12 ? cap : 12, 1);
         send_literal(len, -1);
      end
   endtask

   task automatic write_reg(input logic idx, input logic [lzir_pkg::CFG_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      board.write_register(idx, value);
   endtask

   // hold off until every pending result is in and a trailing code byte is done
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (board.pixels_due.size() != 0) @(negedge clock);
      repeat (RUN_SETTLE) @(negedge clock);
   endtask

   initial begin
      logic [lzir_pkg::CFG_W-1:0] phase_width [7];
      logic [lzir_pkg::CFG_W-1:0] phase_rows  [7];
      int unsigned      mark;
      int unsigned      ending;
      string            ending_name;

      phase_width = '{14'd16383, 14'd1, 14'd37, 14'd8192, 14'd2, 14'd0, 14'd300};
      phase_rows  = '{14'd8192, 14'd16383, 14'd0, 14'd8192, 14'd8191, 14'd0, 14'd16383};
      phase_rows[2]  = 14'($urandom_range(8191, 5000));
      phase_width[5] = 14'($urandom_range(400, 3));
      phase_rows[5]  = 14'($urandom_range(8192, 2000));

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // one-byte rows: single-byte literals at the data extremes
      write_reg(lzir_pkg::REG_BYTES_PER_ROW, 14'd0);
      write_reg(lzir_pkg::REG_ROW_COUNT, 14'd16383);
      send_byte(8'd128, 0);
      send_byte(8'h00, 0);
      send_byte(8'd128, 0);
      send_byte(8'hFF, 0);
      wait_quiet();

      // copies: shortest/nearest, longest reaching unwritten history, longest overlapping
      write_reg(lzir_pkg::REG_BYTES_PER_ROW, 14'd16383);
      send_byte(8'h00, 0);
      send_byte(8'h00, 0);
      send_byte(8'h7F, 0);
      send_byte(8'hFF, 0);
      send_byte(8'h7C, 0);
      send_byte(8'h00, 0);
      send_byte(8'h81, 0);
      send_byte(8'h5A, 0);
      send_byte(8'hC3, 0);
      send_copy(5, 3, 0);
      wait_quiet();

      for (int p = 0; p < 7; p++) begin
         write_reg(lzir_pkg::REG_BYTES_PER_ROW, phase_width[p]);
         // a zero row count would end the image; keep the stream open here
         write_reg(lzir_pkg::REG_ROW_COUNT, (phase_rows[p] == 0) ? 14'd8000 : phase_rows[p]);
         steady = (p == 3);
         mark = board.items_taken;
         while (board.items_taken - mark < 40) send_random_run();
         wait_quiet();
         steady = 0;
      end

      ending = $urandom_range(3);
      case (ending)
         0: begin
            ending_name = "image completion";
            write_reg(lzir_pkg::REG_ROW_COUNT, 14'd0);
            write_reg(lzir_pkg::REG_BYTES_PER_ROW, 14'($urandom_range(40, 1)));
            while (!board.finished) send_row_fill();
         end
         1: begin
            ending_name = "run crossing a row end";
            write_reg(lzir_pkg::REG_BYTES_PER_ROW, 14'($urandom_range(40, 1)));
            mark = board.row_room() + 1;
            if (mark <= 34 && $urandom_range(1)) send_copy(mark < 3 ? 3 : mark, pick_distance(), 0);
            else send_literal(mark, -1);
         end
         2: begin
            ending_name = "early end of input";
            write_reg(lzir_pkg::REG_BYTES_PER_ROW, 14'd16383);
            if (board.row_room() < 21) send_row_fill();
            mark = $urandom_range(20, 2);
            send_literal(mark, $urandom_range(mark, 0));
         end
         default: begin
            ending_name = "early end on a full-length copy";
            write_reg(lzir_pkg::REG_BYTES_PER_ROW, 14'd16383);
            if (board.row_room() < 34) send_row_fill();
            send_copy(34, pick_distance(), 1);
         end
      endcase
      // block is finished: these are taken and dropped
      repeat (4) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      wait_quiet();

      $display("decoded %0d compressed bytes into %0d checked results, %0d row ends",
               board.items_taken, board.results_seen, board.rows_done);
      $display("nine register settings; stream closed by %s", ending_name);
      if (board.mismatches == 0 && board.pixels_due.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
